// ----- hdl/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg: shared constants and types of the palette pixel unpacker
// Opcodes, frame geometry, palette size and the result entry layout.
// ----------------------------------------------------------------------------
package ppu_pkg;

   // index width and frame geometry
   localparam int INDEX_BITS    = 4;
   localparam int FRAME_WIDTH   = 160;
   localparam int FRAME_HEIGHT  = 80;

   localparam int PALETTE_DEPTH = 1 << INDEX_BITS;
   localparam int FRAME_PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int PIX_CNT_W     = $clog2(FRAME_PIXELS + 1);
   localparam int BITS_CNT_W    = $clog2(INDEX_BITS + 1);

   localparam int BYTE_BITS     = 8;
   localparam int AVAIL_W       = $clog2(BYTE_BITS + 1);
   localparam int COLOR_W       = 16;
   localparam int SLOT_W        = 8;

   // request opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_IMAGE = 2'd2;

   // display memory-write command
   localparam logic [COLOR_W-1:0] CMD_MEMORY_WRITE = 16'h002C;

   // result buffer
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic               is_command;
      logic [COLOR_W-1:0] out_word;
      logic               frame_end;
      logic               run_last;
   } rsp_entry_type;

endpackage

// ----- hdl/ppu_ifs.sv -----
// ----------------------------------------------------------------------------
// ppu channel interfaces
// Valid/ready channels for requests into and results out of the unpacker.
// ----------------------------------------------------------------------------
interface ppu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] palette_slot;
   logic [15:0] palette_color;
   logic [7:0] image_byte;

   modport source (output valid, output opcode, output palette_slot,
                   output palette_color, output image_byte, input ready);
   modport sink   (input valid, input opcode, input palette_slot,
                   input palette_color, input image_byte, output ready);
endinterface

interface ppu_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_command;
   logic [15:0] out_word;
   logic        frame_end;
   logic        run_last;

   modport source (output valid, output is_command, output out_word,
                   output frame_end, output run_last, input ready);
   modport sink   (input valid, input is_command, input out_word,
                   input frame_end, input run_last, output ready);
endinterface

// ----- hdl/ppu_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ppu_out_fifo: result buffer of the palette pixel unpacker
// Small register fifo that drives the result channel; the producer only
// pushes when it holds a credit, so a push never finds the buffer full.
// ----------------------------------------------------------------------------
module ppu_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  ppu_pkg::rsp_entry_type        push_entry,
   output logic [ppu_pkg::OUT_LVL_W-1:0] level,
   ppu_rsp_if.source                     rsp_chan
);
   import ppu_pkg::*;

   rsp_entry_type          entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_LVL_W-1:0]   level_ff, level_in;
   logic                   pop;
   rsp_entry_type          head;

   assign head  = entry_ff[rd_ptr_ff];
   assign pop   = rsp_chan.valid && rsp_chan.ready;
   assign level = level_ff;

   assign rsp_chan.valid      = (level_ff != '0);
   assign rsp_chan.is_command = head.is_command;
   assign rsp_chan.out_word   = head.out_word;
   assign rsp_chan.frame_end  = head.frame_end;
   assign rsp_chan.run_last   = head.run_last;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push_valid && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push_valid && pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/palette_pixel_unpacker.sv -----
// ----------------------------------------------------------------------------
// palette_pixel_unpacker: packed palette indexes to 16-bit display colors
// Unpacks image bytes lsb first into indexes, looks each one up in a palette
// memory and emits color words; a start request emits the memory-write
// command and restarts the frame.
// ----------------------------------------------------------------------------
// a request waits in the unpack stage, its palette read and tags are registered in
//   the read stage, and its result is then buffered; one result per cycle while
//   the buffer has credit; an image byte holds the unpack stage until it has yielded
//   its pixels (up to two at 4 bits), and a new request is taken as the old one finishes
// the rate is set by the single read port of the palette memory
// reset clears the unpacker, pixel count and result buffer; palette entries
//   hold nothing defined until they are loaded
module palette_pixel_unpacker (
   input  logic      clock,
   input  logic      reset,
   ppu_req_if.sink   req_chan,
   ppu_rsp_if.source rsp_chan
);
   import ppu_pkg::*;

   // request held in the unpack stage
   logic                  item_valid_ff, item_valid_in;
   logic [1:0]            item_op_ff;
   logic [SLOT_W-1:0]     item_slot_ff;
   logic [COLOR_W-1:0]    item_color_ff;
   logic [BYTE_BITS-1:0]  shreg_ff, shreg_in;
   logic [AVAIL_W-1:0]    avail_ff, avail_in;

   // unpacker state
   index_type             partial_ff, partial_in;
   logic [BITS_CNT_W-1:0] bits_ff, bits_in;
   logic [PIX_CNT_W-1:0]  pix_cnt_ff, pix_cnt_in;

   // palette memory and read stage
   logic [COLOR_W-1:0]    palette_mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0]    rd_data_ff;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_cmd_ff, s1_fend_ff, s1_last_ff;

   // step logic
   logic                  req_fire;
   logic                  is_load, is_start, is_image;
   logic                  frame_done, needs_emit, credit_ok, step_go, item_done;
   logic [AVAIL_W-1:0]    take, avail_after;
   logic [BYTE_BITS-1:0]  take_mask, new_bits, shreg_after;
   logic [15:0]           idx_wide;
   index_type             step_index;
   logic [PIX_CNT_W-1:0]  pix_after;
   logic                  frame_end, byte_last;
   logic                  mem_wr_en, mem_rd_en;

   logic [OUT_LVL_W-1:0]  fifo_level;
   rsp_entry_type         push_entry;

   assign is_load  = (item_op_ff == OP_LOAD);
   assign is_start = (item_op_ff == OP_START);
   assign is_image = (item_op_ff == OP_IMAGE);

   // one index per step: gather the missing bits from the front of the byte
   assign take        = AVAIL_W'(INDEX_BITS) - AVAIL_W'(bits_ff);
   assign take_mask   = BYTE_BITS'((9'd1 << take) - 9'd1);
   assign new_bits    = shreg_ff & take_mask;
   assign idx_wide    = 16'(partial_ff) | (16'(new_bits) << bits_ff);
   assign step_index  = idx_wide[INDEX_BITS-1:0];
   assign avail_after = avail_ff - take;
   assign shreg_after = shreg_ff >> take;

   assign frame_done = (pix_cnt_ff == PIX_CNT_W'(FRAME_PIXELS));
   assign pix_after  = pix_cnt_ff + 1'b1;
   assign frame_end  = (pix_after == PIX_CNT_W'(FRAME_PIXELS));
   // too few bits left for a whole index, or the frame ends: this pixel closes the byte
   assign byte_last  = frame_end || (avail_after < AVAIL_W'(INDEX_BITS));

   // credit: results in flight plus buffered must fit in the buffer
   assign credit_ok = ((OUT_LVL_W + 1)'(fifo_level) + (OUT_LVL_W + 1)'(s1_valid_ff))
                      < (OUT_LVL_W + 1)'(OUT_DEPTH);

   assign needs_emit = is_start || (is_image && !frame_done);
   assign step_go    = item_valid_ff && (!needs_emit || credit_ok);
   assign item_done  = step_go && (!is_image || frame_done || byte_last);

   assign req_chan.ready = !item_valid_ff || item_done;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // load writes land after all reads of earlier bytes were issued
   assign mem_wr_en = step_go && is_load && ((9)'(item_slot_ff) < (9)'(PALETTE_DEPTH));
   assign mem_rd_en = step_go && is_image && !frame_done;

   always_comb begin
      item_valid_in = item_valid_ff;
      shreg_in      = shreg_ff;
      avail_in      = avail_ff;
      partial_in    = partial_ff;
      bits_in       = bits_ff;
      pix_cnt_in    = pix_cnt_ff;

      if (item_done) begin
         item_valid_in = 1'b0;
      end else if (step_go && is_image) begin
         // more pixels to come from this byte
         shreg_in = shreg_after;
         avail_in = avail_after;
      end
      if (req_fire) begin
         item_valid_in = 1'b1;
         shreg_in      = req_chan.image_byte;
         avail_in      = AVAIL_W'(BYTE_BITS);
      end

      if (step_go && is_start) begin
         partial_in = '0;
         bits_in    = '0;
         pix_cnt_in = '0;
      end else if (mem_rd_en) begin
         pix_cnt_in = pix_after;
         if (byte_last && !frame_end) begin
            // leftover bits start the next index
            partial_in = shreg_after[INDEX_BITS-1:0];
            bits_in    = BITS_CNT_W'(avail_after);
         end else begin
            partial_in = '0;
            bits_in    = '0;
         end
      end

      s1_valid_in = step_go && needs_emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         partial_ff    <= '0;
         bits_ff       <= '0;
         pix_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         partial_ff    <= partial_in;
         bits_ff       <= bits_in;
         pix_cnt_ff    <= pix_cnt_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      avail_ff <= avail_in;
      if (req_fire) begin
         item_op_ff    <= req_chan.opcode;
         item_slot_ff  <= req_chan.palette_slot;
         item_color_ff <= req_chan.palette_color;
      end
   end

   // palette memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         palette_mem[item_slot_ff[INDEX_BITS-1:0]] <= item_color_ff;
      end
      if (mem_rd_en) begin
         rd_data_ff <= palette_mem[step_index];
      end
   end

   // tags that travel beside the memory read
   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_cmd_ff  <= is_start;
         s1_fend_ff <= is_image && frame_end;
         s1_last_ff <= is_start || byte_last;
      end
   end

   always_comb begin
      push_entry.is_command = s1_cmd_ff;
      push_entry.out_word   = s1_cmd_ff ? CMD_MEMORY_WRITE : rd_data_ff;
      push_entry.frame_end  = s1_fend_ff;
      push_entry.run_last   = s1_last_ff;
   end

   ppu_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_entry (push_entry),
      .level      (fifo_level),
      .rsp_chan   (rsp_chan)
   );

   // a push always finds room in the buffer
   a_credit: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_level != OUT_LVL_W'(OUT_DEPTH)))
      else $error("result pushed into a full buffer");

   // gathered bits never amount to a whole index between steps
   a_bits: assert property (@(posedge clock) disable iff (reset)
      bits_ff < BITS_CNT_W'(INDEX_BITS))
      else $error("partial index holds a complete index");

   a_pix: assert property (@(posedge clock) disable iff (reset)
      pix_cnt_ff <= PIX_CNT_W'(FRAME_PIXELS))
      else $error("pixel count past end of frame");

   // the command word is alone for its request and never ends a frame
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_cmd_ff) |-> (s1_last_ff && !s1_fend_ff))
      else $error("command word with wrong flags");

   // bytes after a finished frame produce nothing
   a_frame_stop: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && is_image && frame_done) |=> !s1_valid_ff)
      else $error("result from a byte after frame end");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the palette pixel unpacker
// Drives load, start and image-byte requests with random gaps and response
// stalls, predicts every color and command word from a shadow palette and
// unpacker state, and compares each response field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import ppu_pkg::*;

   // opcode the block must ignore
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   // cycles with no handshake on either side before the run is abandoned
   localparam int         STALL_LIMIT = 1000;
   // cycles to wait after the last expected word, well over the latency
   localparam int         DRAIN_CYCLES = 24;
   // mismatch lines printed before the bench goes quiet
   localparam int         PRINT_LIMIT = 40;
   // image bytes in the closing stretch with no idling
   localparam int         FLAT_BYTES  = 16;

   logic clock;
   logic reset;

   ppu_req_if req_bus ();
   ppu_rsp_if rsp_bus ();

   palette_pixel_unpacker u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow state of the unpacker
   logic [COLOR_W-1:0] palette_shadow [PALETTE_DEPTH];
   logic [7:0]         index_shadow;
   int                 index_bits_held;
   int                 frame_pixel_count;

   // words the block still owes, oldest first
   rsp_entry_type      expected_words [$];
   rsp_entry_type      want;

   int                 mismatch_count;
   int                 random_items;
   bit                 idling_on;
   int                 hold_request;
   int                 hold_left;
   int                 gap_left;
   int                 quiet_cycles;

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // one line per mismatch, counted always, printed up to a limit
   task automatic report_mismatch(input string what, input logic [15:0] want_v,
                                  input logic [15:0] got_v);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("tb: mismatch %s: expected %h got %h at %0t", what, want_v, got_v,
                  $realtime);
   endtask

   // compute the words one accepted request causes and queue them
   task automatic unpack_request(input logic [1:0] op, input logic [7:0] slot,
                                 input logic [15:0] color, input logic [7:0] pix);
      rsp_entry_type run_words [8];
      rsp_entry_type word;
      int            made;
      int            avail;
      int            take;
      logic [7:0]    chunk;
      made = 0;
      case (op)
         OP_LOAD: begin
            // slots past the palette are dropped
            if (slot < PALETTE_DEPTH)
               palette_shadow[slot[INDEX_BITS-1:0]] = color;
         end
         OP_START: begin
            // a start throws away any half-gathered index
            index_shadow      = '0;
            index_bits_held   = 0;
            frame_pixel_count = 0;
            word.is_command   = 1'b1;
            word.out_word     = CMD_MEMORY_WRITE;
            word.frame_end    = 1'b0;
            word.run_last     = 1'b1;
            expected_words.push_back(word);
         end
         OP_IMAGE: begin
            avail = BYTE_BITS;
            // bits after the final pixel of the frame are dropped
            while (avail > 0 && frame_pixel_count < FRAME_PIXELS) begin
               take = INDEX_BITS - index_bits_held;
               if (take > avail)
                  take = avail;
               chunk = (pix >> (BYTE_BITS - avail)) & ((8'd1 << take) - 8'd1);
               index_shadow    = index_shadow | (chunk << index_bits_held);
               index_bits_held += take;
               avail           -= take;
               if (index_bits_held >= INDEX_BITS) begin
                  frame_pixel_count++;
                  word.is_command = 1'b0;
                  word.out_word   = palette_shadow[index_shadow[INDEX_BITS-1:0]];
                  word.frame_end  = (frame_pixel_count == FRAME_PIXELS);
                  word.run_last   = 1'b0;
                  run_words[made] = word;
                  made++;
                  index_shadow    = '0;
                  index_bits_held = 0;
               end
            end
            if (made > 0)
               run_words[made-1].run_last = 1'b1;
            for (int i = 0; i < made; i++)
               expected_words.push_back(run_words[i]);
         end
         default: ;
      endcase
   endtask

   // offer one request, maybe after a random gap, and predict it on acceptance
   task automatic send_request(input logic [1:0] op, input logic [7:0] slot,
                               input logic [15:0] color, input logic [7:0] pix);
      int gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.palette_slot  <= slot;
      req_bus.palette_color <= color;
      req_bus.image_byte    <= pix;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      unpack_request(op, slot, color, pix);
   endtask

   // image byte with the unused fields scrambled
   task automatic send_image(input logic [7:0] pix);
      send_request(OP_IMAGE, 8'($urandom), 16'($urandom), pix);
   endtask

   task automatic send_start();
      send_request(OP_START, 8'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // fill every palette entry first so no lookup ever hits an empty slot
   task automatic test_palette_load();
      send_request(OP_LOAD, 8'd0, 16'h0000, 8'($urandom));
      send_request(OP_LOAD, 8'd1, 16'hFFFF, 8'($urandom));
      for (int s = 2; s < PALETTE_DEPTH; s++)
         send_request(OP_LOAD, 8'(s), 16'($urandom), 8'($urandom));
      // loads past the palette must not alias onto low slots
      send_request(OP_LOAD, 8'(PALETTE_DEPTH), 16'hAAAA, 8'($urandom));
      send_request(OP_LOAD, 8'd255, 16'h5555, 8'($urandom));
   endtask

   // bytes before any start decode as if a frame began at reset
   task automatic test_before_start();
      send_image(8'h10);
      send_image(8'hFF);
      send_image(8'h00);
      send_image(8'hA5);
   endtask

   // start words, the ignored opcode and back-to-back starts
   task automatic test_commands();
      send_request(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
      send_start();
      send_image(8'h01);
      send_start();
      send_start();
      send_image(8'hFE);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_start();
      hold_request = 120;
      for (int i = 0; i < 30; i++)
         send_image(8'($urandom));
   endtask

   // mostly well-formed frames with random content, some noise between
   task automatic test_random_frames();
      int run_len;
      int pick;
      random_items = 0;
      while (random_items < 280) begin
         if ($urandom_range(0, 99) < 85) begin
            send_start();
            random_items++;
         end
         run_len = $urandom_range(1, 24);
         for (int i = 0; i < run_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               // reload mid-frame, sometimes to a slot past the palette
               if ($urandom_range(0, 1) == 0)
                  send_request(OP_LOAD, 8'($urandom_range(0, PALETTE_DEPTH - 1)),
                               16'($urandom), 8'($urandom));
               else
                  send_request(OP_LOAD, 8'($urandom), 16'($urandom), 8'($urandom));
            end else if (pick < 11) begin
               send_request(OP_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom));
               random_items--;
            end else if (pick < 14) begin
               send_start();
            end else begin
               send_image(8'($urandom));
            end
            random_items++;
         end
      end
   endtask

   // closing stretch with requests and responses back to back
   task automatic test_flat_out();
      send_start();
      for (int i = 0; i < FLAT_BYTES; i++)
         send_image(8'($urandom));
      send_start();
      send_image(8'($urandom));
   endtask

   // response ready: long hold when asked, random stall bursts otherwise
   initial begin
      hold_left     = 0;
      gap_left      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (gap_left == 0 && idling_on && $urandom_range(0, 7) == 0)
               gap_left = $urandom_range(1, 9);
            if (gap_left > 0) begin
               gap_left--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // compare every accepted response with the oldest expected word
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            report_mismatch("response with nothing expected", 16'h0, rsp_bus.out_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_bus.is_command !== want.is_command)
               report_mismatch("is_command", 16'(want.is_command), 16'(rsp_bus.is_command));
            if (rsp_bus.out_word !== want.out_word)
               report_mismatch("out_word", want.out_word, rsp_bus.out_word);
            if (rsp_bus.frame_end !== want.frame_end)
               report_mismatch("frame_end", 16'(want.frame_end), 16'(rsp_bus.frame_end));
            if (rsp_bus.run_last !== want.run_last)
               report_mismatch("run_last", 16'(want.run_last), 16'(rsp_bus.run_last));
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // main sequence
   initial begin
      mismatch_count        = 0;
      idling_on             = 1'b0;
      hold_request          = 0;
      index_shadow          = '0;
      index_bits_held       = 0;
      frame_pixel_count     = 0;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.opcode        <= OP_LOAD;
      req_bus.palette_slot  <= '0;
      req_bus.palette_color <= '0;
      req_bus.image_byte    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idling_on = 1'b1;
      test_palette_load();
      test_before_start();
      test_commands();
      test_backpressure();
      test_random_frames();
      // last stretch runs flat out on both sides
      idling_on = 1'b0;
      test_flat_out();
      req_bus.valid <= 1'b0;

      // wait for the block to drain, then a margin for stray words
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ppu_pkg.sv
hdl/ppu_ifs.sv
hdl/ppu_out_fifo.sv
hdl/palette_pixel_unpacker.sv
tb/tb.sv
